>>> rtl/abr_pkg.sv
// shared types, constants and checksum helper for the alternating-bit receiver
package abr_pkg;

    localparam int unsigned COUNT_W = 11;
    localparam logic [COUNT_W-1:0] COUNT_LIMIT = 11'd2047;
    localparam logic [7:0] PAD_RESET = 8'h30;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_END  = 1'b1;

    localparam logic KIND_ECHO    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef struct packed {
        logic        command;
        logic [7:0]  payload_byte;
        logic        seq_bit;
        logic [15:0] rx_checksum;
    } t_in_item;

    typedef struct packed {
        logic       out_kind;
        logic [7:0] data_out;
        logic       commit;
        logic       send_ack;
        logic       ack_seq;
        logic       bad_checksum;
        logic       duplicate;
        logic       too_long;
    } t_out_item;

    typedef struct packed {
        logic        is_end;
        logic [7:0]  data;
        logic        seq;
        logic [15:0] rx_sum;
    } t_q_entry;

    typedef struct packed {
        logic     valid;
        t_q_entry entry;
    } t_q_head;

    function automatic logic [15:0] oc_add(input logic [15:0] acc, input logic [15:0] word);
        logic [16:0] s;
        s = {1'b0, acc} + {1'b0, word};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

>>> rtl/abr_front.sv
// front end: accepts requests, classifies them and queues them for the back end
module abr_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  abr_pkg::t_in_item   i_in_item,
    output abr_pkg::t_q_head    o_head,
    input  logic                i_pop
);

    abr_pkg::t_q_entry r_mem [2];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_count;
    logic [1:0]        n_count;
    logic              push;
    abr_pkg::t_q_entry entry;

    assign o_in_stall = (r_count == 2'd2);
    assign push       = i_in_valid && !o_in_stall;

    always_comb begin
        entry.is_end = (i_in_item.command == abr_pkg::CMD_END);
        entry.data   = i_in_item.payload_byte;
        entry.seq    = i_in_item.seq_bit;
        entry.rx_sum = i_in_item.rx_checksum;
    end

    always_comb begin
        n_count = r_count;
        if (push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= entry;
        end
    end

    assign o_head.valid = (r_count != 2'd0);
    assign o_head.entry = r_mem[r_rd_ptr];

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("queue count out of range");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != 2'd0)
        else $error("pop from empty queue");

    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 || r_count == 2'd2) |-> r_wr_ptr == r_rd_ptr)
        else $error("queue pointers inconsistent with count");
`endif

endmodule

>>> rtl/abr_back.sv
// back end: checksum, sequence tracking and verdict with registered output
module abr_back #(
    parameter int MAX_PAYLOAD = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  abr_pkg::t_q_head    i_head,
    output logic                o_pop,
    input  logic                i_cfg_valid,
    input  logic [7:0]          i_cfg_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output abr_pkg::t_out_item  o_out_item
);

    localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD);

    logic [7:0]                    r_pad;
    logic                          r_expected_seq;
    logic                          r_prev_ack_valid;
    logic [15:0]                   r_sum;
    logic [7:0]                    r_held;
    logic                          r_odd;
    logic [abr_pkg::COUNT_W-1:0]   r_count;
    logic                          r_overflow;
    logic                          r_out_valid;
    abr_pkg::t_out_item            r_out;

    logic                          n_expected_seq;
    logic                          n_prev_ack_valid;
    logic [15:0]                   n_sum;
    logic [7:0]                    n_held;
    logic                          n_odd;
    logic [abr_pkg::COUNT_W-1:0]   n_count;
    logic                          n_overflow;
    logic                          n_out_valid;
    abr_pkg::t_out_item            n_out;

    logic                          take;
    logic [15:0]                   byte_sum;
    logic [15:0]                   end_sum;
    logic [15:0]                   computed;
    logic                          bad;
    logic                          dup;
    logic                          longp;

    assign take  = !r_out_valid || !i_out_stall;
    assign o_pop = i_head.valid && take;

    assign byte_sum = abr_pkg::oc_add(r_sum, {r_held, i_head.entry.data});
    assign end_sum  = r_odd ? abr_pkg::oc_add(r_sum, {r_held, r_pad}) : r_sum;
    assign computed = ~end_sum;
    assign bad      = (computed != i_head.entry.rx_sum);
    assign dup      = (i_head.entry.seq != r_expected_seq);
    assign longp    = r_overflow;

    always_comb begin
        n_expected_seq   = r_expected_seq;
        n_prev_ack_valid = r_prev_ack_valid;
        n_sum            = r_sum;
        n_held           = r_held;
        n_odd            = r_odd;
        n_count          = r_count;
        n_overflow       = r_overflow;
        n_out_valid      = r_out_valid && i_out_stall;
        n_out            = r_out;
        if (o_pop) begin
            n_out_valid = 1'b1;
            n_out       = '0;
            if (!i_head.entry.is_end) begin
                if ({5'd0, r_count} >= MAX_LEN) begin
                    n_overflow = 1'b1;
                end
                if (r_count < abr_pkg::COUNT_LIMIT) begin
                    n_count = r_count + 1'b1;
                end
                if (r_odd) begin
                    n_sum = byte_sum;
                    n_odd = 1'b0;
                end else begin
                    n_held = i_head.entry.data;
                    n_odd  = 1'b1;
                end
                n_out.out_kind = abr_pkg::KIND_ECHO;
                n_out.data_out = i_head.entry.data;
            end else begin
                n_out.out_kind     = abr_pkg::KIND_VERDICT;
                n_out.bad_checksum = bad;
                n_out.duplicate    = dup;
                n_out.too_long     = longp;
                if (!bad && !dup && !longp) begin
                    n_out.commit     = 1'b1;
                    n_out.send_ack   = 1'b1;
                    n_out.ack_seq    = i_head.entry.seq;
                    n_expected_seq   = ~i_head.entry.seq;
                    n_prev_ack_valid = 1'b1;
                end else begin
                    n_out.send_ack = r_prev_ack_valid;
                    n_out.ack_seq  = r_prev_ack_valid & ~r_expected_seq;
                end
                n_sum      = '0;
                n_held     = '0;
                n_odd      = 1'b0;
                n_count    = '0;
                n_overflow = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pad            <= abr_pkg::PAD_RESET;
            r_expected_seq   <= 1'b0;
            r_prev_ack_valid <= 1'b0;
            r_sum            <= '0;
            r_held           <= '0;
            r_odd            <= 1'b0;
            r_count          <= '0;
            r_overflow       <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_pad <= i_cfg_data;
            end
            r_expected_seq   <= n_expected_seq;
            r_prev_ack_valid <= n_prev_ack_valid;
            r_sum            <= n_sum;
            r_held           <= n_held;
            r_odd            <= n_odd;
            r_count          <= n_count;
            r_overflow       <= n_overflow;
            r_out_valid      <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef SYNTHESIS
    a_commit_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.commit) |-> (r_out.send_ack && !r_out.bad_checksum
            && !r_out.duplicate && !r_out.too_long))
        else $error("commit issued with an error flag");

    a_echo_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.out_kind == abr_pkg::KIND_ECHO) |-> (!r_out.commit
            && !r_out.send_ack && !r_out.ack_seq && !r_out.bad_checksum
            && !r_out.duplicate && !r_out.too_long))
        else $error("echo carries verdict fields");

    a_overflow_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_overflow |-> ({5'd0, r_count} >= MAX_LEN))
        else $error("overflow flag without enough bytes");

    a_commit_flip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_head.entry.is_end && !bad && !dup && !longp)
            |=> r_expected_seq != $past(r_expected_seq))
        else $error("expected sequence did not flip on commit");
`endif

endmodule

>>> rtl/alternating_bit_receiver_core.sv
// top level of the alternating-bit stop-and-wait receiver
// a request is stored in the two-entry queue and its result is then held in the output register
// throughput: one request per cycle while the output is not stalled
// a two-entry queue parts the front and back ends, the output register parts the back end
// reset is synchronous, active low; it clears sequence, ack and packet state
// and sets the pad byte to ascii zero
module alternating_bit_receiver_core #(
    parameter int MAX_PAYLOAD = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  abr_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output abr_pkg::t_out_item  o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [7:0]          i_cfg_data
);

    abr_pkg::t_q_head head;
    logic             pop;

    assign o_cfg_ready = 1'b1;

    abr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_head     (head),
        .i_pop      (pop)
    );

    abr_back #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_pop       (pop),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

>>> dv/testbench.sv
// testbench for the alternating-bit receiver: packet traffic checked against a scoreboard
`timescale 1ns / 1ps

module testbench;

    localparam int PAYLOAD_LIMIT = 1024;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE_CYCLES = 8;

    typedef enum {FILL_RANDOM, FILL_ONES, FILL_ZEROS, FILL_ALTERNATE} t_fill;
    typedef enum {SEQ_EXPECTED, SEQ_WRONG, SEQ_RANDOM} t_seq_pick;
    typedef enum {SUM_GOOD, SUM_FLIPPED, SUM_RANDOM} t_sum_pick;

    class t_receiver_tracker;
        logic [7:0] pad;
        logic expected_seq;
        logic ack_valid;
        logic [15:0] running_sum;
        logic [7:0] held_high;
        logic odd_pending;
        logic [abr_pkg::COUNT_W-1:0] byte_count;
        logic overflow_seen;
        abr_pkg::t_out_item pending_results[$];
        int errors;

        function new();
            pad = abr_pkg::PAD_RESET;
            expected_seq = 1'b0;
            ack_valid = 1'b0;
            errors = 0;
            clear_packet();
        endfunction

        function void clear_packet();
            running_sum = '0;
            held_high = '0;
            odd_pending = 1'b0;
            byte_count = '0;
            overflow_seen = 1'b0;
        endfunction

        function logic [15:0] fold(logic [15:0] acc, logic [15:0] word);
            logic [16:0] s;
            s = {1'b0, acc} + {1'b0, word};
            return s[15:0] + {15'd0, s[16]};
        endfunction

        // checksum the block will compute for the packet in progress
        function logic [15:0] good_checksum();
            logic [15:0] s;
            s = running_sum;
            if (odd_pending) s = fold(s, {held_high, pad});
            return ~s;
        endfunction

        function void note_request(abr_pkg::t_in_item it);
            abr_pkg::t_out_item e;
            logic bad;
            logic dup;
            logic lng;
            e = '0;
            if (it.command == abr_pkg::CMD_BYTE) begin
                if (byte_count >= PAYLOAD_LIMIT) overflow_seen = 1'b1;
                if (byte_count != abr_pkg::COUNT_LIMIT) byte_count = byte_count + 1'b1;
                if (odd_pending) begin
                    running_sum = fold(running_sum, {held_high, it.payload_byte});
                    odd_pending = 1'b0;
                end else begin
                    held_high = it.payload_byte;
                    odd_pending = 1'b1;
                end
                e.out_kind = abr_pkg::KIND_ECHO;
                e.data_out = it.payload_byte;
            end else begin
                bad = good_checksum() != it.rx_checksum;
                dup = it.seq_bit != expected_seq;
                lng = overflow_seen;
                e.out_kind = abr_pkg::KIND_VERDICT;
                e.bad_checksum = bad;
                e.duplicate = dup;
                e.too_long = lng;
                if (!bad && !dup && !lng) begin
                    e.commit = 1'b1;
                    e.send_ack = 1'b1;
                    e.ack_seq = it.seq_bit;
                    expected_seq = ~it.seq_bit;
                    ack_valid = 1'b1;
                end else begin
                    e.send_ack = ack_valid;
                    e.ack_seq = ack_valid ? ~expected_seq : 1'b0;
                end
                clear_packet();
            end
            pending_results.push_back(e);
        endfunction

        function void check_field(string name, logic [15:0] e, logic [15:0] g);
            if (g !== e) begin
                $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, e, g);
                errors++;
            end
        endfunction

        function void check_result(abr_pkg::t_out_item got);
            abr_pkg::t_out_item e;
            if (pending_results.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, actual %p", $time, got);
                errors++;
                return;
            end
            e = pending_results.pop_front();
            check_field("out_kind", 16'(e.out_kind), 16'(got.out_kind));
            check_field("data_out", 16'(e.data_out), 16'(got.data_out));
            check_field("commit", 16'(e.commit), 16'(got.commit));
            check_field("send_ack", 16'(e.send_ack), 16'(got.send_ack));
            check_field("ack_seq", 16'(e.ack_seq), 16'(got.ack_seq));
            check_field("bad_checksum", 16'(e.bad_checksum), 16'(got.bad_checksum));
            check_field("duplicate", 16'(e.duplicate), 16'(got.duplicate));
            check_field("too_long", 16'(e.too_long), 16'(got.too_long));
        endfunction

        function void check_leftover();
            if (pending_results.size() != 0) begin
                $display("%0t ns: %0d expected results never arrived, expected 0, actual %0d",
                         $time, pending_results.size(), pending_results.size());
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    abr_pkg::t_in_item i_in_item;
    logic o_out_valid;
    logic i_out_stall;
    abr_pkg::t_out_item o_out_item;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [7:0] i_cfg_data;

    t_receiver_tracker trk;
    int burst_left;
    int cycle_count;
    int stall_left;
    int stall_mode;

    alternating_bit_receiver_core #(
        .MAX_PAYLOAD(PAYLOAD_LIMIT)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in_item(i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item(o_out_item),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) trk.check_result(o_out_item);
    end

    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 200);
        end
        stall_left--;
        case (stall_mode)
            0: i_out_stall = 1'b0;
            1: i_out_stall = ($urandom_range(0, 3) == 0);
            2: i_out_stall = ($urandom_range(0, 9) < 7);
            default: i_out_stall = ((stall_left % 8) < 3);
        endcase
    end

    task automatic send_request(input abr_pkg::t_in_item it);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                                     : $urandom_range(1, 20);
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                @(negedge i_clk);
                i_in_valid = 1'b0;
                i_in_item = abr_pkg::t_in_item'($bits(abr_pkg::t_in_item)'($urandom()));
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_in_item = it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        trk.note_request(it);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (trk.pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_pad(input logic [7:0] value);
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data = value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        trk.pad = value;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        i_cfg_data = 8'($urandom());
    endtask

    task automatic send_packet(input int len, input t_fill fill, input t_seq_pick sq,
                               input t_sum_pick sm);
        abr_pkg::t_in_item it;
        logic [15:0] good;
        for (int i = 0; i < len; i++) begin
            it.command = abr_pkg::CMD_BYTE;
            it.seq_bit = 1'($urandom_range(0, 1));
            it.rx_checksum = 16'($urandom_range(0, 65535));
            case (fill)
                FILL_ONES: it.payload_byte = 8'hFF;
                FILL_ZEROS: it.payload_byte = 8'h00;
                FILL_ALTERNATE: it.payload_byte = (i % 2) ? 8'h00 : 8'hFF;
                default: it.payload_byte = 8'($urandom_range(0, 255));
            endcase
            send_request(it);
        end
        it.command = abr_pkg::CMD_END;
        it.payload_byte = 8'($urandom_range(0, 255));
        case (sq)
            SEQ_EXPECTED: it.seq_bit = trk.expected_seq;
            SEQ_WRONG: it.seq_bit = ~trk.expected_seq;
            default: it.seq_bit = 1'($urandom_range(0, 1));
        endcase
        good = trk.good_checksum();
        case (sm)
            SUM_GOOD: it.rx_checksum = good;
            SUM_FLIPPED: it.rx_checksum = good ^ (16'h1 << $urandom_range(0, 15));
            default: it.rx_checksum = 16'($urandom_range(0, 65535));
        endcase
        send_request(it);
    endtask

    task automatic random_traffic(input int item_goal);
        int sent;
        int pick;
        int len;
        t_fill fill;
        t_seq_pick sq;
        t_sum_pick sm;
        sent = 0;
        while (sent < item_goal) begin
            pick = $urandom_range(0, 99);
            len = (pick < 70) ? $urandom_range(0, 12)
                : (pick < 95) ? $urandom_range(13, 60) : $urandom_range(61, 200);
            fill = ($urandom_range(0, 9) < 7) ? FILL_RANDOM : t_fill'($urandom_range(1, 3));
            pick = $urandom_range(0, 99);
            sq = (pick < 85) ? SEQ_EXPECTED : (pick < 93) ? SEQ_WRONG : SEQ_RANDOM;
            pick = $urandom_range(0, 99);
            sm = (pick < 85) ? SUM_GOOD : (pick < 93) ? SUM_FLIPPED : SUM_RANDOM;
            send_packet(len, fill, sq, sm);
            sent += len + 1;
            if ($urandom_range(0, 199) == 0) drain();
        end
    endtask

    initial begin
        trk = new();
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        burst_left = 0;
        cycle_count = 0;
        stall_left = 0;
        stall_mode = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // no ack exists yet, then empty commit, then a resent ack
        send_packet(0, FILL_RANDOM, SEQ_WRONG, SUM_GOOD);
        send_packet(0, FILL_RANDOM, SEQ_EXPECTED, SUM_GOOD);
        send_packet(0, FILL_RANDOM, SEQ_WRONG, SUM_GOOD);
        send_packet(3, FILL_ONES, SEQ_EXPECTED, SUM_GOOD);
        send_packet(4, FILL_ZEROS, SEQ_EXPECTED, SUM_FLIPPED);
        send_packet(2, FILL_ALTERNATE, SEQ_WRONG, SUM_RANDOM);
        send_packet(1, FILL_RANDOM, SEQ_EXPECTED, SUM_GOOD);
        send_packet(4, FILL_ALTERNATE, SEQ_EXPECTED, SUM_GOOD);
        drain();

        write_pad(8'h00);
        random_traffic(250);

        write_pad(8'hFF);
        // payload one byte past the limit
        send_packet(PAYLOAD_LIMIT + 1, FILL_RANDOM, SEQ_EXPECTED, SUM_GOOD);
        random_traffic(250);

        write_pad(8'($urandom_range(1, 254)));
        random_traffic(200);

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        trk.check_leftover();
        if (trk.errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
